/* rtl/hts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, constants and the control store of the hop table shuffle
// generator: beat formats, micro-op codes, jump conditions and the program.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int          UPC_W           = 4;
  localparam logic [7:0]  CFG_COUNT_RESET = 8'd80;
  localparam logic [31:0] LCG_MUL         = 32'd1664525;
  localparam logic [31:0] LCG_ADD         = 32'd1013904223;
  localparam int          LCG_SHIFT       = 16;
  localparam int          DIVIDEND_W      = 32 - LCG_SHIFT;
  localparam int          DIV_CNT_W       = $clog2(DIVIDEND_W);

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] seed;
    logic [6:0]  hop_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0] channel;
    logic       index_error;
  } out_item_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_GEN_INIT,
    A_LCG,
    A_DIV_INIT,
    A_DIV_STEP,
    A_RD_SWAP,
    A_WR_TOP,
    A_WR_J,
    A_RD_LOOKUP,
    A_RESULT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_LOOKUP,
    C_I_LE1,
    C_DIV_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic lookup;
    logic i_le1;
    logic div_busy;
  } status_t;

  localparam upc_t U_IDLE     = 4'd0;
  localparam upc_t U_DISPATCH = 4'd1;
  localparam upc_t U_GEN_INIT = 4'd2;
  localparam upc_t U_LOOP     = 4'd3;
  localparam upc_t U_LCG      = 4'd4;
  localparam upc_t U_DIV_INIT = 4'd5;
  localparam upc_t U_DIV_STEP = 4'd6;
  localparam upc_t U_RD_SWAP  = 4'd7;
  localparam upc_t U_WR_TOP   = 4'd8;
  localparam upc_t U_WR_J     = 4'd9;
  localparam upc_t U_LK_RD    = 4'd10;
  localparam upc_t U_LK_OUT   = 4'd11;

  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t w;
    case (addr)
      U_IDLE:     w = '{op: A_ACCEPT,    cond: C_NO_START, target: U_IDLE};
      U_DISPATCH: w = '{op: A_NONE,      cond: C_LOOKUP,   target: U_LK_RD};
      U_GEN_INIT: w = '{op: A_GEN_INIT,  cond: C_NEVER,    target: U_IDLE};
      U_LOOP:     w = '{op: A_NONE,      cond: C_I_LE1,    target: U_IDLE};
      U_LCG:      w = '{op: A_LCG,       cond: C_NEVER,    target: U_IDLE};
      U_DIV_INIT: w = '{op: A_DIV_INIT,  cond: C_NEVER,    target: U_IDLE};
      U_DIV_STEP: w = '{op: A_DIV_STEP,  cond: C_DIV_BUSY, target: U_DIV_STEP};
      U_RD_SWAP:  w = '{op: A_RD_SWAP,   cond: C_NEVER,    target: U_IDLE};
      U_WR_TOP:   w = '{op: A_WR_TOP,    cond: C_NEVER,    target: U_IDLE};
      U_WR_J:     w = '{op: A_WR_J,      cond: C_ALWAYS,   target: U_LOOP};
      U_LK_RD:    w = '{op: A_RD_LOOKUP, cond: C_NEVER,    target: U_IDLE};
      U_LK_OUT:   w = '{op: A_RESULT,    cond: C_ALWAYS,   target: U_IDLE};
      default:    w = '{op: A_NONE,      cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/hop_table_shuffle_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_table_shuffle_generator_unit
// Lookup: accept, dispatch, table read, result, registered out_strobe beat;
// one item at a time. Generate: count - 1 swaps for a count of two or more,
// else none; a swap is loop test, LCG, remainder setup, 16 remainder steps,
// one table read and two table writes. No result; results cannot be stalled.
// Reset (rst_n low, synchronous) restores identity order, count 80, LCG 0.
// ----------------------------------------------------------------------------
module hop_table_shuffle_generator_unit #(
  parameter int MAX_CHANNELS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hts_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output hts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import hts_pkg::*;

  ctrl_word_t ctrl;
  status_t    status;
  logic [7:0] count_r;
  logic       res_valid;
  out_item_t  res_data;
  logic       strobe_r;
  out_item_t  data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CFG_COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  hts_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  hts_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .start     (start),
    .in_data   (in_data),
    .cfg_count (count_r),
    .status    (status),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res_data;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

/* rtl/hts_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_sequencer
// Micro-program counter over the control store, with conditional jumps
// selected by the control word and tested against datapath status.
// ----------------------------------------------------------------------------
module hts_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  hts_pkg::status_t    status,
  output hts_pkg::ctrl_word_t ctrl,
  output logic                busy
);
  import hts_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic taken;

  assign ctrl = ucode_rom(upc_r);
  assign busy = (upc_r != U_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_START: taken = !status.start;
      C_LOOKUP:   taken = status.lookup;
      C_I_LE1:    taken = status.i_le1;
      C_DIV_BUSY: taken = status.div_busy;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt = taken ? ctrl.target : upc_t'(upc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* rtl/hts_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_table
// Hop table storage: one write port, two registered read ports, and a valid
// bit per entry so that an unwritten entry reads as its own index.
// ----------------------------------------------------------------------------
module hts_table #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  output logic [AW-1:0] rd_data_a,
  output logic [AW-1:0] rd_data_b
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    q_a_r;
  logic [AW-1:0]    q_b_r;
  logic [AW-1:0]    addr_a_r;
  logic [AW-1:0]    addr_b_r;
  logic             vld_a_r;
  logic             vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_a_r    <= mem[rd_addr_a];
      q_b_r    <= mem[rd_addr_b];
      vld_a_r  <= valid_r[rd_addr_a];
      vld_b_r  <= valid_r[rd_addr_b];
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data_a = vld_a_r ? q_a_r : addr_a_r;
  assign rd_data_b = vld_b_r ? q_b_r : addr_b_r;

endmodule

/* rtl/hts_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_datapath
// Operand registers, LCG, bit-serial remainder unit and table access,
// each driven by the micro-op of the current control word.
// ----------------------------------------------------------------------------
module hts_datapath #(
  parameter int MAX_CHANNELS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hts_pkg::ctrl_word_t ctrl,
  input  logic                start,
  input  hts_pkg::in_item_t   in_data,
  input  logic [7:0]          cfg_count,
  output hts_pkg::status_t    status,
  output logic                res_valid,
  output hts_pkg::out_item_t  res_data
);
  import hts_pkg::*;

  localparam int AW  = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int EXW = (CW > 8) ? CW : 8;
  localparam int IXW = (AW > 7) ? AW : 7;
  localparam int ECW = (CW > 7) ? CW : 7;

  logic                  mode_r;
  logic [31:0]           seed_r;
  logic [6:0]            idx_r;
  logic [31:0]           lcg_r;
  logic [31:0]           lcg_nxt;
  logic [CW-1:0]         i_r;
  logic [CW-1:0]         rem_r;
  logic [CW-1:0]         rem_nxt;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIV_CNT_W-1:0]  bit_r;
  logic [CW:0]           trial;
  logic [CW-1:0]         eff_count;
  logic [EXW-1:0]        cfg_ext;
  logic [EXW-1:0]        max_ext;
  logic [CW-1:0]         top_full;
  logic [AW-1:0]         top_addr;
  logic [AW-1:0]         j_addr;
  logic [IXW-1:0]        idx_ext;
  logic                  idx_err;
  logic                  tb_clear;
  logic                  tb_rd_en;
  logic [AW-1:0]         tb_rd_addr_a;
  logic                  tb_wr_en;
  logic [AW-1:0]         tb_wr_addr;
  logic [AW-1:0]         tb_wr_data;
  logic [AW-1:0]         tb_rd_data_a;
  logic [AW-1:0]         tb_rd_data_b;
  logic [IXW-1:0]        chan_ext;

  assign cfg_ext   = EXW'(cfg_count);
  assign max_ext   = EXW'(MAX_CHANNELS);
  assign eff_count = (cfg_ext > max_ext) ? max_ext[CW-1:0] : cfg_ext[CW-1:0];

  assign top_full = i_r - CW'(1);
  assign top_addr = top_full[AW-1:0];
  assign j_addr   = rem_r[AW-1:0];
  assign idx_ext  = IXW'(idx_r);
  assign idx_err  = (ECW'(idx_r) >= ECW'(eff_count));

  assign lcg_nxt = lcg_r * LCG_MUL + LCG_ADD;

  always_comb begin
    trial = {rem_r, q_r[DIVIDEND_W-1]};
    if (trial >= {1'b0, i_r}) begin
      rem_nxt = CW'(trial - {1'b0, i_r});
    end else begin
      rem_nxt = trial[CW-1:0];
    end
  end

  assign status.start    = start;
  assign status.lookup   = mode_r;
  assign status.i_le1    = (i_r <= CW'(1));
  assign status.div_busy = (bit_r != DIV_CNT_W'(DIVIDEND_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r <= '0;
      i_r   <= '0;
    end else begin
      case (ctrl.op)
        A_GEN_INIT: begin
          lcg_r <= seed_r;
          i_r   <= eff_count;
        end
        A_LCG:  lcg_r <= lcg_nxt;
        A_WR_J: i_r   <= top_full;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      A_ACCEPT: begin
        if (start) begin
          mode_r <= in_data.mode;
          seed_r <= in_data.seed;
          idx_r  <= in_data.hop_index;
        end
      end
      A_DIV_INIT: begin
        rem_r <= '0;
        q_r   <= lcg_r[31:LCG_SHIFT];
        bit_r <= '0;
      end
      A_DIV_STEP: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIVIDEND_W-2:0], 1'b0};
        bit_r <= bit_r + DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    tb_clear     = (ctrl.op == A_GEN_INIT);
    tb_rd_en     = (ctrl.op == A_RD_SWAP) || (ctrl.op == A_RD_LOOKUP);
    tb_rd_addr_a = (ctrl.op == A_RD_LOOKUP) ? idx_ext[AW-1:0] : top_addr;
    tb_wr_en     = (ctrl.op == A_WR_TOP) || (ctrl.op == A_WR_J);
    tb_wr_addr   = (ctrl.op == A_WR_TOP) ? top_addr : j_addr;
    tb_wr_data   = (ctrl.op == A_WR_TOP) ? tb_rd_data_b : tb_rd_data_a;
  end

  hts_table #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (tb_clear),
    .rd_en     (tb_rd_en),
    .rd_addr_a (tb_rd_addr_a),
    .rd_addr_b (j_addr),
    .wr_en     (tb_wr_en),
    .wr_addr   (tb_wr_addr),
    .wr_data   (tb_wr_data),
    .rd_data_a (tb_rd_data_a),
    .rd_data_b (tb_rd_data_b)
  );

  assign chan_ext              = IXW'(tb_rd_data_a);
  assign res_valid             = (ctrl.op == A_RESULT);
  assign res_data.channel      = idx_err ? 7'd0 : chan_ext[6:0];
  assign res_data.index_error  = idx_err;

endmodule
